/* rtl/core/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// No dependencies; imported by the allocator core.
package bba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int FILE_ID_BITS = 8;
   localparam int ADDR_BITS    = 6;
   localparam int CNT_BITS     = 7;
   localparam int MODE_BITS    = 2;
   localparam int STATUS_BITS  = 2;
   localparam int ENTRY_BITS   = FILE_ID_BITS + 1;

   localparam logic [CNT_BITS-1:0] BLOCK_COUNT_RESET = CNT_BITS'(MAX_BLOCKS);
   localparam logic [CNT_BITS-1:0] MAX_BLOCKS_CNT    = CNT_BITS'(MAX_BLOCKS);

   localparam logic [MODE_BITS-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PRELOAD = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_GRANTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SHORT   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FREED   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CLAIM,
      ST_FREE
   } state_type;

endpackage

/* rtl/core/bitmap_block_allocator_core.sv */
// Bitmap block allocator core: block table memory, scan sequencer and result register.
// Depends on bba_pkg for widths, mode and status codes and the sequencer states.
//
// The block keeps a used bit and an owner file id for each disk block in one
// synchronous memory, read one entry per cycle through a registered read port.
// A request is taken when start is high and busy is low. An allocate request
// makes a counting pass over the blocks in use and, when enough blocks are
// free, a claiming pass that stops after the last granted block; the passes
// run one after the other over the single read port of the block table. A
// free request makes one pass. A preload request is done in its accept cycle
// and gives no result. Results appear on the rsp_ ports for exactly one cycle,
// marked by rsp_valid; the receiver cannot stall them, so they must be taken
// when shown. Each entry has a valid flip-flop that reset clears, so the
// table reads as all free right after reset with no clearing pass. The
// block_count register may be written only while busy is low.
module bitmap_block_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bba_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [bba_pkg::FILE_ID_BITS-1:0]    req_file_id,
   input  logic [bba_pkg::CNT_BITS-1:0]        req_blocks_wanted,
   input  logic [bba_pkg::ADDR_BITS-1:0]       req_preload_block,
   output logic                                rsp_valid,
   output logic [bba_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [bba_pkg::ADDR_BITS-1:0]       rsp_granted_block,
   output logic [bba_pkg::CNT_BITS-1:0]        rsp_freed_count,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bba_pkg::CNT_BITS-1:0]        csr_block_count
);
   import bba_pkg::*;

   // Configuration register.
   logic [CNT_BITS-1:0]     block_count_ff;
   logic [CNT_BITS-1:0]     n_blocks;

   // Sequencer state.
   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     idx_ff, idx_in;
   logic [CNT_BITS-1:0]     tally_ff, tally_in;
   logic [CNT_BITS-1:0]     remain_ff, remain_in;
   logic [FILE_ID_BITS-1:0] id_ff, id_in;

   // Read pipeline: the address issued last cycle and whether it was issued.
   logic                    s1_vld_ff;
   logic [ADDR_BITS-1:0]    s1_idx_ff;
   logic                    issue;
   logic                    pass_done;
   logic                    accept;

   // Block table and its per-entry valid bits.
   logic [ENTRY_BITS-1:0]   mem [MAX_BLOCKS];
   logic [ENTRY_BITS-1:0]   mem_q_ff;
   logic [MAX_BLOCKS-1:0]   valid_ff;
   logic                    vld_q_ff;
   logic                    used_q;
   logic [FILE_ID_BITS-1:0] owner_q;

   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ENTRY_BITS-1:0]   wr_data;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]    rsp_block_ff, rsp_block_in;
   logic [CNT_BITS-1:0]     rsp_freed_ff, rsp_freed_in;
   logic                    rsp_last_ff, rsp_last_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Values above the table size count as the whole table.
   assign n_blocks = (block_count_ff > MAX_BLOCKS_CNT) ? MAX_BLOCKS_CNT : block_count_ff;

   // A pass issues one read per cycle until every block in use has been
   // addressed; it is over once the last read has also been processed.
   assign issue     = busy && (idx_ff < n_blocks);
   assign pass_done = (idx_ff >= n_blocks) && !s1_vld_ff;

   // An entry whose valid bit is clear reads as free with no owner.
   assign used_q  = vld_q_ff && mem_q_ff[ENTRY_BITS-1];
   assign owner_q = vld_q_ff ? mem_q_ff[FILE_ID_BITS-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         block_count_ff <= csr_block_count;
      end
   end

   // Block table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[idx_ff[ADDR_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_q_ff <= valid_ff[idx_ff[ADDR_BITS-1:0]];
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ALLOC) begin
                  state_in = ST_COUNT;
               end else if (req_mode == MODE_FREE) begin
                  state_in = ST_FREE;
               end
            end
         end
         ST_COUNT: begin
            if (pass_done) begin
               if ((remain_ff > tally_ff) || (remain_ff == '0)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CLAIM;
               end
            end
         end
         ST_CLAIM: begin
            // Leave on the last grant; a read still in flight is then ignored.
            if ((s1_vld_ff && !used_q && (remain_ff == CNT_BITS'(1))) || pass_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (pass_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, table writes and results.
   always_comb begin
      idx_in        = issue ? idx_ff + CNT_BITS'(1) : idx_ff;
      tally_in      = tally_ff;
      remain_in     = remain_ff;
      id_in         = id_ff;
      wr_en         = 1'b0;
      wr_addr       = s1_idx_ff;
      wr_data       = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_GRANTED;
      rsp_block_in  = '0;
      rsp_freed_in  = '0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = '0;
               tally_in  = '0;
               remain_in = req_blocks_wanted;
               id_in     = req_file_id;
               if ((req_mode == MODE_PRELOAD) &&
                   ({1'b0, req_preload_block} < MAX_BLOCKS_CNT)) begin
                  wr_en   = 1'b1;
                  wr_addr = req_preload_block;
                  wr_data = {1'b1, {FILE_ID_BITS{1'b0}}};
               end
            end
         end
         ST_COUNT: begin
            if (s1_vld_ff && !used_q) begin
               tally_in = tally_ff + CNT_BITS'(1);
            end
            if (pass_done) begin
               idx_in       = '0;
               rsp_last_in  = 1'b1;
               if (remain_ff > tally_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_SHORT;
               end else if (remain_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NONE;
               end
            end
         end
         ST_CLAIM: begin
            if (s1_vld_ff && !used_q && (remain_ff != '0)) begin
               wr_en         = 1'b1;
               wr_data       = {1'b1, id_ff};
               remain_in     = remain_ff - CNT_BITS'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_GRANTED;
               rsp_block_in  = s1_idx_ff;
               rsp_last_in   = (remain_ff == CNT_BITS'(1));
            end
         end
         ST_FREE: begin
            if (s1_vld_ff && used_q && (owner_q == id_ff) && (id_ff != '0)) begin
               wr_en    = 1'b1;
               wr_data  = '0;
               tally_in = tally_ff + CNT_BITS'(1);
            end
            if (pass_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FREED;
               rsp_freed_in  = tally_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tally_ff      <= tally_in;
      remain_ff     <= remain_in;
      id_ff         <= id_in;
      s1_idx_ff     <= idx_ff[ADDR_BITS-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_block_ff;
   assign rsp_freed_count   = rsp_freed_ff;
   assign rsp_last_result   = rsp_last_ff;

   // A claiming pass only runs while grants are still owed.
   a_claim_owes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAIM) |-> (remain_ff != '0))
      else $error("claim pass running with nothing left to grant");

   // A grant that is not the last one leaves the sequencer in the claim pass.
   a_grant_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> (state_ff == ST_CLAIM))
      else $error("non-final grant without a running claim pass");

   // Granted blocks lie among the blocks in use.
   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_GRANTED)) |->
         ({1'b0, rsp_granted_block} < n_blocks))
      else $error("granted block outside the blocks in use");

   // Table writes from a pass never coincide with a preload.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_IDLE)) |-> (accept && (req_mode == MODE_PRELOAD)))
      else $error("table write in idle without a preload request");

endmodule
